[sv/dsiq_pkg.sv]
// Shared types and constants for the date-sorted insert queue.
// Used by dsiq_cell and date_sorted_insert_queue_top; no dependencies.
package dsiq_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 7;
  localparam int TAG_W   = 8;

  localparam logic [YEAR_W-1:0]  YEAR_MAX       = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_MAX      = MONTH_W'(99);
  localparam logic [YEAR_W-1:0]  RECENT_YEAR_RST = YEAR_W'(2000);

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_READ   = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_INSERTED   = 2'd0,
    ST_DROPPED    = 2'd1,
    ST_READ_OK    = 2'd2,
    ST_READ_EMPTY = 2'd3
  } status_t;

  // Upper fields ordered so that {recent, year, month} is the rank.
  typedef struct packed {
    logic               recent;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [TAG_W-1:0]   tag;
  } rec_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctrl_t;

endpackage

[sv/dsiq_cell.sv]
// One slot of the sorted chain: holds a record, decides insert/shift/pop.
// Depends on dsiq_pkg.
module dsiq_cell
  import dsiq_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  rec_t             new_rec,
  input  logic [CNT_W-1:0] count,
  input  rec_t             left_rec,
  input  logic             left_take,
  input  rec_t             right_rec,
  output rec_t             rec_o,
  output logic             take_o
);

  rec_t rec_r;
  rec_t rec_nxt;

  // Take: the new record belongs at or before this slot.
  assign take_o = (CNT_W'(IDX) >= count) ||
                  ({rec_r.recent, rec_r.year, rec_r.month} <
                   {new_rec.recent, new_rec.year, new_rec.month});
  assign rec_o  = rec_r;

  always_comb begin
    rec_nxt = rec_r;
    if (ctrl.insert) begin
      if (take_o && !left_take) begin
        rec_nxt = new_rec;
      end else if (take_o) begin
        rec_nxt = left_rec;
      end
    end else if (ctrl.pop) begin
      rec_nxt = right_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

[sv/date_sorted_insert_queue_top.sv]
// Top level of the date-sorted insert queue: stream ports, fill count,
// result register and the chain of dsiq_cell slots. Depends on dsiq_pkg.
//
// The queue keeps up to DEPTH records newest first: recent records (year
// above the configured threshold at insert time) ahead of the rest, then
// larger year*100+month first, equal ranks in arrival order. Each beat on
// the input is either an insert or a read of the head. Every slot compares
// its own record with the incoming one and shifts, loads or holds in the
// same cycle, so the result of an accepted item is registered and offered on
// the output from the next cycle. A new beat is taken only while the result
// register is empty or its result leaves in the same cycle, so with the
// receiver ready the stream runs at one beat per clock and a stalled
// receiver stalls the input. An insert into a full queue is dropped
// and reported; a read of an empty queue returns status read-empty with
// zero fields. Slots beyond the fill count hold stale data and are never
// shown. The threshold register may only be written while the queue is idle.
module date_sorted_insert_queue_top
  import dsiq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // config: recent_after_year
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] cfg_data,
  // in_tuser: kind (0 insert, 1 read)
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,
  // in_tdata: year[13:0], month[20:14], item_tag[28:21], zero[31:29]
  input  logic [31:0] in_tdata,
  // out_tuser: status
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,
  // out_tdata: out_tag[7:0], out_year[21:8], out_month[28:22], is_recent[29], zero[31:30]
  output logic [31:0] out_tdata
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [YEAR_W-1:0] recent_year_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  rec_t              out_rec_r, out_rec_nxt;

  logic              in_acc;
  kind_t             kind;
  logic              full, empty;
  logic [YEAR_W-1:0]  year_sat;
  logic [MONTH_W-1:0] month_sat;
  rec_t              new_rec;
  cell_ctrl_t        ctrl;

  rec_t cell_rec  [DEPTH];
  logic cell_take [DEPTH];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_year_r <= RECENT_YEAR_RST;
    end else if (cfg_valid && cfg_ready) begin
      recent_year_r <= cfg_data;
    end
  end

  // Accept while the result register is empty or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign kind      = kind_t'(in_tuser);
  assign full      = (count_r == FULL_CNT);
  assign empty     = (count_r == '0);

  // Clamp out-of-range dates before ranking and the recent test.
  always_comb begin
    year_sat  = in_tdata[13:0];
    month_sat = in_tdata[20:14];
    if (year_sat > YEAR_MAX) begin
      year_sat = YEAR_MAX;
    end
    if (month_sat > MONTH_MAX) begin
      month_sat = MONTH_MAX;
    end
    new_rec.recent = (year_sat > recent_year_r);
    new_rec.year   = year_sat;
    new_rec.month  = month_sat;
    new_rec.tag    = in_tdata[28:21];
  end

  assign ctrl.insert = in_acc && (kind == KIND_INSERT) && !full;
  assign ctrl.pop    = in_acc && (kind == KIND_READ) && !empty;

  // Chain of slots; slot 0 is the head.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t left_rec;
    logic left_take;
    rec_t right_rec;

    if (i == 0) begin : g_head
      assign left_rec  = new_rec;
      assign left_take = 1'b0;
    end else begin : g_mid
      assign left_rec  = cell_rec[i-1];
      assign left_take = cell_take[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_rec = cell_rec[i];
    end else begin : g_body
      assign right_rec = cell_rec[i+1];
    end

    dsiq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .new_rec   (new_rec),
      .count     (count_r),
      .left_rec  (left_rec),
      .left_take (left_take),
      .right_rec (right_rec),
      .rec_o     (cell_rec[i]),
      .take_o    (cell_take[i])
    );
  end

  // Fill count and result register.
  always_comb begin
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_rec_nxt    = out_rec_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_rec_nxt   = '0;
      if (kind == KIND_INSERT) begin
        if (full) begin
          out_status_nxt = ST_DROPPED;
        end else begin
          out_status_nxt = ST_INSERTED;
          count_nxt      = count_r + 1'b1;
        end
      end else begin
        if (empty) begin
          out_status_nxt = ST_READ_EMPTY;
        end else begin
          out_status_nxt = ST_READ_OK;
          out_rec_nxt    = cell_rec[0];
          count_nxt      = count_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_rec_r    <= out_rec_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_rec_r.recent, out_rec_r.month,
                       out_rec_r.year, out_rec_r.tag};

  // Fill count never passes the chain length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("fill count above depth");

  // Insert into a full chain leaves the count alone and reports a drop.
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && kind == KIND_INSERT && full)
      |=> (count_r == $past(count_r)) && (out_tuser == ST_DROPPED))
    else $error("insert into full queue not dropped");

  // Read of an empty chain reports empty with zero payload.
  a_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && kind == KIND_READ && empty)
      |=> (out_tuser == ST_READ_EMPTY) && (out_tdata == '0))
    else $error("empty read result wrong");

  // A held result is only released by a taken output beat.
  a_out_release: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_tready))
    else $error("result dropped without output beat");

endmodule

[tb/tb_date_sorted_insert_queue_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for date_sorted_insert_queue_top: a directed table,
// then random inserts and reads under varying back-pressure and thresholds.
// Depends on dsiq_pkg and the top level; needs nothing else.
module tb_date_sorted_insert_queue_top;
  import dsiq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int HOLD_CYCLES = 120;
  localparam int RAND_BLOCKS = 6;
  localparam int BLOCK_ITEMS = 113;

  // One result beat, fields as they leave the block.
  typedef struct packed {
    status_t            status;
    logic [TAG_W-1:0]   tag;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic               recent;
  } queue_result_t;

  // One row of the directed table; res is used only where typed is set.
  typedef struct packed {
    kind_t              kind;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [TAG_W-1:0]   tag;
    logic               typed;
    queue_result_t      res;
  } directed_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [13:0] cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic        in_tuser   = 1'b0;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;
  logic [31:0] out_tdata;

  // Shadow copy of the sorted store and the threshold register.
  logic [19:0]        shadow_key    [QUEUE_DEPTH];
  logic [TAG_W-1:0]   shadow_tag    [QUEUE_DEPTH];
  logic               shadow_recent [QUEUE_DEPTH];
  int                 shadow_count  = 0;
  logic [YEAR_W-1:0]  recent_thr    = RECENT_YEAR_RST;

  queue_result_t pending_results [$];
  directed_row_t directed_rows   [$];

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  logic holding      = 1'b0;
  event hold_off_ev;

  int mismatch_count = 0;
  int beats_sent     = 0;
  int results_seen   = 0;
  int drops_seen     = 0;
  int empty_reads    = 0;
  int thr_writes     = 0;
  int hold_offs      = 0;

  date_sorted_insert_queue_top #(
    .DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Generous ceiling on the whole run; a correct run takes a small fraction.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still outstanding", pending_results.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic queue_result_t mk_result(status_t st, logic [TAG_W-1:0] tg,
                                              logic [YEAR_W-1:0] yr,
                                              logic [MONTH_W-1:0] mo, logic rc);
    queue_result_t r;
    r.status = st;
    r.tag    = tg;
    r.year   = yr;
    r.month  = mo;
    r.recent = rc;
    return r;
  endfunction

  // Apply one beat to the shadow store and return the result it must give.
  function automatic queue_result_t predict_queue_op(kind_t k, logic [YEAR_W-1:0] yr,
                                                     logic [MONTH_W-1:0] mo,
                                                     logic [TAG_W-1:0] tg);
    queue_result_t      r;
    logic [YEAR_W-1:0]  yr_sat;
    logic [MONTH_W-1:0] mo_sat;
    logic [19:0]        key;
    logic               rec;
    int                 pos;
    r = mk_result(ST_INSERTED, '0, '0, '0, 1'b0);
    if (k == KIND_INSERT) begin
      yr_sat = (yr > YEAR_MAX) ? YEAR_MAX : yr;
      mo_sat = (mo > MONTH_MAX) ? MONTH_MAX : mo;
      key    = 20'(yr_sat * 100 + mo_sat);
      rec    = (yr_sat > recent_thr);
      if (shadow_count >= QUEUE_DEPTH) begin
        r.status = ST_DROPPED;
        return r;
      end
      // Slot the record in ahead of the first entry that ranks strictly lower,
      // so equal ranks stay in arrival order.
      pos = shadow_count;
      for (int i = 0; i < shadow_count; i++) begin
        if ((shadow_recent[i] != rec) ? (shadow_recent[i] < rec)
                                      : (shadow_key[i] < key)) begin
          pos = i;
          break;
        end
      end
      for (int i = shadow_count; i > pos; i--) begin
        shadow_key[i]    = shadow_key[i-1];
        shadow_tag[i]    = shadow_tag[i-1];
        shadow_recent[i] = shadow_recent[i-1];
      end
      shadow_key[pos]    = key;
      shadow_tag[pos]    = tg;
      shadow_recent[pos] = rec;
      shadow_count++;
      return r;
    end
    if (shadow_count == 0) begin
      r.status = ST_READ_EMPTY;
      return r;
    end
    r.status = ST_READ_OK;
    r.tag    = shadow_tag[0];
    r.year   = YEAR_W'(shadow_key[0] / 100);
    r.month  = MONTH_W'(shadow_key[0] % 100);
    r.recent = shadow_recent[0];
    for (int i = 0; i + 1 < shadow_count; i++) begin
      shadow_key[i]    = shadow_key[i+1];
      shadow_tag[i]    = shadow_tag[i+1];
      shadow_recent[i] = shadow_recent[i+1];
    end
    shadow_count--;
    return r;
  endfunction

  task automatic add_row(kind_t k, logic [YEAR_W-1:0] yr, logic [MONTH_W-1:0] mo,
                         logic [TAG_W-1:0] tg, logic typed, queue_result_t res);
    directed_row_t row;
    row.kind  = k;
    row.year  = yr;
    row.month = mo;
    row.tag   = tg;
    row.typed = typed;
    row.res   = res;
    directed_rows.push_back(row);
  endtask

  // Offer one beat, with a random gap first, and hold it until taken. The
  // expectation is queued at the accepting edge.
  task automatic send_beat(kind_t k, logic [YEAR_W-1:0] yr, logic [MONTH_W-1:0] mo,
                           logic [TAG_W-1:0] tg, logic typed, queue_result_t typed_res);
    int            gap;
    queue_result_t predicted;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(4, 1) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {3'b000, tg, mo, yr};
    do @(posedge clk); while (!in_tready);
    predicted = predict_queue_op(k, yr, mo, tg);
    pending_results.push_back(typed ? typed_res : predicted);
    beats_sent++;
  endtask

  // Drop valid, wait until every queued result has come out, then let the
  // result register settle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_threshold(logic [YEAR_W-1:0] thr);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    recent_thr = thr;
    thr_writes++;
  endtask

  // Random beat. Years cluster round the threshold so both groups and many
  // equal keys turn up; a fifth range over the whole field.
  task automatic send_random_beat(int insert_pct);
    kind_t k;
    int    sel;
    int    yr;
    int    mo;
    k   = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_READ;
    sel = $urandom_range(9);
    if (sel < 2) begin
      yr = $urandom_range(16383);
      mo = $urandom_range(127);
    end else if (sel < 4) begin
      yr = int'(recent_thr) + $urandom_range(1);
      mo = $urandom_range(2);
    end else begin
      yr = int'(recent_thr) + $urandom_range(12) - 6;
      if (yr < 0) yr = 0;
      mo = ($urandom_range(9) == 0) ? $urandom_range(127, 100) : $urandom_range(99);
    end
    send_beat(k, YEAR_W'(yr), MONTH_W'(mo), TAG_W'($urandom_range(255)), 1'b0,
              mk_result(ST_INSERTED, '0, '0, '0, 1'b0));
  endtask

  // Receiver ready: random idling, or held low during a hold-off.
  always @(posedge clk) begin
    out_tready <= holding ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // Long receiver hold-off, counted here so the sender carries on meanwhile.
  initial begin : hold_off_counter
    int n;
    forever begin
      @(hold_off_ev);
      holding <= 1'b1;
      for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      holding <= 1'b0;
      hold_offs++;
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin : result_check
    queue_result_t got;
    queue_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = status_t'(out_tuser);
      got.tag    = out_tdata[7:0];
      got.year   = out_tdata[21:8];
      got.month  = out_tdata[28:22];
      got.recent = out_tdata[29];
      results_seen++;
      if (got.status == ST_DROPPED) drops_seen++;
      if (got.status == ST_READ_EMPTY) empty_reads++;
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got status %0d tag %0d",
                 $time, got.status, got.tag);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, got.status);
        check_field("tag", want.tag, got.tag);
        check_field("year", want.year, got.year);
        check_field("month", want.month, got.month);
        check_field("recent", want.recent, got.recent);
      end
    end
  end

  initial begin : stimulus
    queue_result_t no_res;
    queue_result_t ins_res;
    logic [YEAR_W-1:0] thr_list [RAND_BLOCKS];
    int insert_pct;
    int burst_left;

    no_res  = mk_result(ST_INSERTED, '0, '0, '0, 1'b0);
    ins_res = no_res;

    // Directed table: threshold at its reset value of 2000 throughout.
    add_row(KIND_READ,   14'd0,     7'd0,   8'h00, 1'b1,
            mk_result(ST_READ_EMPTY, '0, '0, '0, 1'b0));
    add_row(KIND_INSERT, 14'd9999,  7'd99,  8'hFF, 1'b1, ins_res);
    // Year and month above range saturate to the same key as the row above.
    add_row(KIND_INSERT, 14'd16383, 7'd127, 8'h00, 1'b1, ins_res);
    add_row(KIND_INSERT, 14'd0,     7'd0,   8'h55, 1'b1, ins_res);
    // Year equal to the threshold is not recent; one above is.
    add_row(KIND_INSERT, 14'd2000,  7'd6,   8'hAA, 1'b1, ins_res);
    add_row(KIND_INSERT, 14'd2001,  7'd1,   8'h11, 1'b1, ins_res);
    add_row(KIND_INSERT, 14'd2000,  7'd6,   8'hAB, 1'b1, ins_res);
    // Read fields are ignored, so fill them with ones.
    add_row(KIND_READ,   14'd16383, 7'd127, 8'hFF, 1'b1,
            mk_result(ST_READ_OK, 8'hFF, 14'd9999, 7'd99, 1'b1));
    add_row(KIND_READ,   14'd0,     7'd0,   8'h00, 1'b1,
            mk_result(ST_READ_OK, 8'h00, 14'd9999, 7'd99, 1'b1));
    add_row(KIND_READ,   14'd0,     7'd0,   8'h00, 1'b0, no_res);
    // Three entries remain; fill the store to the brim.
    for (int i = 0; i < QUEUE_DEPTH - 3; i++) begin
      add_row(KIND_INSERT, 14'(1990 + 3 * i), 7'(9 * i), 8'(8'h30 + i), 1'b0, no_res);
    end
    add_row(KIND_INSERT, 14'd1234,  7'd5,   8'h77, 1'b1,
            mk_result(ST_DROPPED, '0, '0, '0, 1'b0));
    add_row(KIND_READ,   14'd0,     7'd0,   8'h00, 1'b0, no_res);

    // Thresholds per random block: both extremes, back to reset, and random.
    thr_list[0] = 14'd0;
    thr_list[1] = 14'd9999;
    thr_list[2] = 14'($urandom_range(9999));
    thr_list[3] = RECENT_YEAR_RST;
    thr_list[4] = 14'($urandom_range(9999));
    thr_list[5] = 14'($urandom_range(9999));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 36;
    recv_idle_pct = 51;
    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].kind, directed_rows[i].year, directed_rows[i].month,
                directed_rows[i].tag, directed_rows[i].typed, directed_rows[i].res);
    end

    for (int b = 0; b < RAND_BLOCKS; b++) begin
      // Swap idling sides after two blocks, then stop idling altogether.
      if (b < 2) begin
        send_idle_pct = 36;
        recv_idle_pct = 51;
      end else if (b < 4) begin
        send_idle_pct = 51;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Write only with nothing in flight; the store itself may hold entries,
      // which keep the mark they were given on insert.
      write_threshold(thr_list[b]);
      burst_left = 0;
      insert_pct = 50;
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        // Bursts that fill, drain or churn the store.
        if (burst_left == 0) begin
          burst_left = $urandom_range(20, 8);
          case ($urandom_range(2))
            0:       insert_pct = 85;
            1:       insert_pct = 20;
            default: insert_pct = 55;
          endcase
        end
        burst_left--;
        if (b == 1 && n == 50) drain_results();
        if (b == 4 && n == 40) -> hold_off_ev;
        send_random_beat(insert_pct);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, pending_results.size());
      mismatch_count++;
    end
    $display("Ran %0d beats, %0d results checked: %0d drops on a full store,", beats_sent,
             results_seen, drops_seen);
    $display("%0d reads of an empty store, %0d threshold writes, %0d receiver hold-offs",
             empty_reads, thr_writes, hold_offs);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
